FILE: rtl/kgnq_pkg.sv
// Shared types, constants and helpers for the k-mer neighbour query block.
// No dependencies; used by kgnq_canon and kmer_graph_neighbour_query.
`default_nettype none

package kgnq_pkg;

    // Value coding: two bits per letter, first letter most significant
    localparam int KMER_W       = 16;
    localparam int KMER_LETTERS = KMER_W / 2;
    localparam int LEN_W        = 4;

    // Longest k-mer supported; usable length is capped by the value width
    localparam int MAX_K = 8;
    localparam int K_CAP = (MAX_K < KMER_LETTERS) ? MAX_K : KMER_LETTERS;
    localparam int K_MIN = 2;

    // Presence bitmap: rows of ROW_W bits
    localparam int ROW_W      = 16;
    localparam int BIT_AW     = $clog2(ROW_W);
    localparam int ROW_AW     = KMER_W - BIT_AW;
    localparam int ROWS       = 1 << ROW_AW;

    localparam int MASK_W     = 8;
    localparam int STEP_W     = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KMER_LENGTH    = 2'd0,
        REG_ALPHABET_ORDER = 2'd1
    } reg_idx_t;

    typedef enum logic {
        ORDER_ACGT = 1'b0,
        ORDER_ACTG = 1'b1
    } order_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_CANON    = 2'd1,
        ST_BELOW_LAST   = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } status_t;

    localparam logic [LEN_W-1:0] KMER_LEN_RESET = LEN_W'(8);

    // Mask bit of the forward extension by letter code a (A,C,G,T -> 7..4)
    function automatic logic [STEP_W-1:0] fwd_pos(input logic order, input logic [1:0] a);
        logic [STEP_W-1:0] pos;
        pos = STEP_W'(7) - {1'b0, a};
        if (order == ORDER_ACTG) begin
            if (a == 2'd2) begin
                pos = STEP_W'(4);
            end else if (a == 2'd3) begin
                pos = STEP_W'(5);
            end
        end
        return pos;
    endfunction

    // kmer_length saturated into the legal range
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] k;
        k = len;
        if (k > LEN_W'(K_CAP)) begin
            k = LEN_W'(K_CAP);
        end
        if (k < LEN_W'(K_MIN)) begin
            k = LEN_W'(K_MIN);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/kgnq_canon.sv
// Canonicaliser: reverse complement over k letters and min with the input.
// Depends on kgnq_pkg.
`default_nettype none

module kgnq_canon (
    input  wire logic [kgnq_pkg::KMER_W-1:0] value,
    input  wire logic [kgnq_pkg::LEN_W-1:0]  kmer_len,
    input  wire logic                        order,
    output logic      [kgnq_pkg::KMER_W-1:0] canon_value,
    output logic                             not_canonical
);

    logic [kgnq_pkg::KMER_W-1:0] cmask;
    logic [kgnq_pkg::KMER_W-1:0] comp;
    logic [kgnq_pkg::KMER_W-1:0] rev;
    logic [kgnq_pkg::KMER_W-1:0] rc;
    logic [kgnq_pkg::LEN_W:0]    rsh;

    // A,C,G,T complements by NOT; A,C,T,G by XOR 2
    assign cmask = (order == kgnq_pkg::ORDER_ACTG) ? {kgnq_pkg::KMER_LETTERS{2'b10}}
                                                   : {kgnq_pkg::KMER_LETTERS{2'b11}};
    assign comp  = value ^ cmask;

    always_comb begin
        rev = '0;
        for (int i = 0; i < kgnq_pkg::KMER_LETTERS; i++) begin
            rev[2*(kgnq_pkg::KMER_LETTERS-1-i) +: 2] = comp[2*i +: 2];
        end
    end

    // letters above k land in the low positions and are shifted out
    assign rsh = {kgnq_pkg::LEN_W'(kgnq_pkg::KMER_LETTERS) - kmer_len, 1'b0};
    assign rc  = rev >> rsh;

    assign not_canonical = value > rc;
    assign canon_value   = not_canonical ? rc : value;

endmodule

`default_nettype wire

FILE: rtl/kmer_graph_neighbour_query.sv
// Top level of the k-mer presence store with de Bruijn neighbour query.
// Depends on kgnq_pkg and kgnq_canon.
`default_nettype none

// Holds a 64K-entry presence bitmap of canonical 2-bit-coded k-mers and
// handles one item at a time. After reset a clearing pass zeroes the bitmap,
// one 16-bit row a cycle; s_ready stays low until it ends (configuration
// writes are taken throughout). An accepted insert goes through accept,
// check with row read, row write and hand-off to the output register; a
// rejected insert through accept, check and hand-off. A query item goes
// through accept, eight extensions one per cycle through the single
// canonicalizer and the single bitmap port, collect of the last bit and
// hand-off; a query out of range through accept, check and hand-off.
// Every item returns exactly one result item; a
// finished result waits in the output register while the next item may
// already be accepted, and the hand-off cycle stretches for as long as the
// previous result is still waiting. Configuration: index 0 is kmer_length
// (saturated into 2..8 when used), index 1 is alphabet_order; other
// indexes are ignored. cfg_ready is always high.

module kmer_graph_neighbour_query (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kgnq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kgnq_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_opcode,
    input  wire logic [kgnq_pkg::KMER_W-1:0]     s_kmer_value,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [1:0]                      m_status,
    output logic      [kgnq_pkg::MASK_W-1:0]     m_neighbour_mask,
    output logic                                 m_any_neighbour
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_CHK,
        S_INS_WR,
        S_QRY,
        S_QRY_TAIL,
        S_DONE
    } state_t;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                          state_reg,    state_next;
    logic [kgnq_pkg::ROW_AW-1:0]     clr_cnt_reg,  clr_cnt_next;
    logic [kgnq_pkg::LEN_W-1:0]      klen_reg,     klen_next;
    logic                            order_reg,    order_next;
    logic [kgnq_pkg::KMER_W-1:0]     last_reg,     last_next;
    logic [kgnq_pkg::KMER_W-1:0]     val_reg,      val_next;
    logic [kgnq_pkg::STEP_W-1:0]     step_reg,     step_next;
    logic                            pend_reg,     pend_next;
    logic [kgnq_pkg::STEP_W-1:0]     pend_pos_reg, pend_pos_next;
    logic [kgnq_pkg::BIT_AW-1:0]     pend_bit_reg, pend_bit_next;
    logic [kgnq_pkg::MASK_W-1:0]     mask_reg,     mask_next;
    kgnq_pkg::status_t               status_reg,   status_next;
    logic                            m_valid_reg,  m_valid_next;
    kgnq_pkg::status_t               m_status_reg, m_status_next;
    logic [kgnq_pkg::MASK_W-1:0]     m_mask_reg,   m_mask_next;

    // ---------------------------------------------------------------
    // Bitmap memory: single port, registered read data
    // ---------------------------------------------------------------
    logic [kgnq_pkg::ROW_W-1:0]  bitmap_mem [kgnq_pkg::ROWS];
    logic [kgnq_pkg::ROW_W-1:0]  rdata_reg;
    logic                        mem_we;
    logic [kgnq_pkg::ROW_AW-1:0] mem_addr;
    logic [kgnq_pkg::ROW_W-1:0]  mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[mem_addr] <= mem_wdata;
        end else begin
            rdata_reg <= bitmap_mem[mem_addr];
        end
    end

    // ---------------------------------------------------------------
    // Shared canonicaliser and extension forming
    // ---------------------------------------------------------------
    logic [kgnq_pkg::LEN_W-1:0]  k_eff;
    logic [kgnq_pkg::LEN_W-1:0]  qshift;
    logic [1:0]                  letter;
    logic [kgnq_pkg::KMER_W-1:0] ext_value;
    logic [kgnq_pkg::KMER_W-1:0] canon_in;
    logic [kgnq_pkg::KMER_W-1:0] canon_value;
    logic                        not_canonical;
    logic                        ins_range_bad;
    logic                        qry_range_bad;
    logic [kgnq_pkg::STEP_W-1:0] fpos;
    logic [kgnq_pkg::STEP_W-1:0] ext_pos;

    assign k_eff  = kgnq_pkg::eff_len(klen_reg);
    assign qshift = {k_eff[kgnq_pkg::LEN_W-2:0], 1'b0} - kgnq_pkg::LEN_W'(2);
    assign letter = step_reg[1:0];

    // steps 0..3 forward X.a, steps 4..7 backward a.X
    assign ext_value = step_reg[2] ? (val_reg | ({{(kgnq_pkg::KMER_W-2){1'b0}}, letter} << qshift))
                                   : {val_reg[kgnq_pkg::KMER_W-3:0], letter};
    assign canon_in  = (state_reg == S_QRY) ? ext_value : val_reg;

    assign fpos    = kgnq_pkg::fwd_pos(order_reg, letter);
    assign ext_pos = {~step_reg[2], fpos[kgnq_pkg::STEP_W-2:0]};

    // value >= 4^k (insert) or >= 4^(k-1) (query)
    assign ins_range_bad = (val_reg >> {k_eff, 1'b0}) != '0;
    assign qry_range_bad = (val_reg >> qshift) != '0;

    kgnq_canon u_canon (
        .value         (canon_in),
        .kmer_len      (k_eff),
        .order         (order_reg),
        .canon_value   (canon_value),
        .not_canonical (not_canonical)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        klen_next     = klen_reg;
        order_next    = order_reg;
        last_next     = last_reg;
        val_next      = val_reg;
        step_next     = step_reg;
        pend_next     = 1'b0;
        pend_pos_next = pend_pos_reg;
        pend_bit_next = pend_bit_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_mask_next   = m_mask_reg;
        mem_we        = 1'b0;
        mem_addr      = val_reg[kgnq_pkg::KMER_W-1 -: kgnq_pkg::ROW_AW];
        mem_wdata     = '0;

        if (cfg_valid) begin
            case (cfg_index)
                kgnq_pkg::REG_KMER_LENGTH:    klen_next  = cfg_data;
                kgnq_pkg::REG_ALPHABET_ORDER: order_next = cfg_data[0];
                default: ;
            endcase
        end

        // collect the bit read in the previous cycle
        if (pend_reg && rdata_reg[pend_bit_reg]) begin
            mask_next = mask_reg | (kgnq_pkg::MASK_W'(1) << pend_pos_reg);
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + kgnq_pkg::ROW_AW'(1);
                if (&clr_cnt_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    val_next    = s_kmer_value;
                    step_next   = '0;
                    mask_next   = '0;
                    status_next = kgnq_pkg::ST_OK;
                    state_next  = (s_opcode == kgnq_pkg::OP_QUERY) ? S_QRY : S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                // row read is issued here regardless; only used when accepted
                if (ins_range_bad) begin
                    status_next = kgnq_pkg::ST_OUT_OF_RANGE;
                    state_next  = S_DONE;
                end else if (not_canonical) begin
                    status_next = kgnq_pkg::ST_NOT_CANON;
                    state_next  = S_DONE;
                end else if (val_reg < last_reg) begin
                    status_next = kgnq_pkg::ST_BELOW_LAST;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_INS_WR;
                end
            end
            S_INS_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = rdata_reg
                           | (kgnq_pkg::ROW_W'(1) << val_reg[kgnq_pkg::BIT_AW-1:0]);
                last_next  = val_reg;
                state_next = S_DONE;
            end
            S_QRY: begin
                if (step_reg == '0 && qry_range_bad) begin
                    status_next = kgnq_pkg::ST_OUT_OF_RANGE;
                    state_next  = S_DONE;
                end else begin
                    mem_addr      = canon_value[kgnq_pkg::KMER_W-1 -: kgnq_pkg::ROW_AW];
                    pend_next     = 1'b1;
                    pend_pos_next = ext_pos;
                    pend_bit_next = canon_value[kgnq_pkg::BIT_AW-1:0];
                    step_next     = step_reg + kgnq_pkg::STEP_W'(1);
                    if (&step_reg) begin
                        state_next = S_QRY_TAIL;
                    end
                end
            end
            S_QRY_TAIL: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_mask_next   = mask_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            klen_reg    <= kgnq_pkg::KMER_LEN_RESET;
            order_reg   <= kgnq_pkg::ORDER_ACGT;
            last_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            klen_reg    <= klen_next;
            order_reg   <= order_next;
            last_reg    <= last_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        val_reg      <= val_next;
        step_reg     <= step_next;
        pend_pos_reg <= pend_pos_next;
        pend_bit_reg <= pend_bit_next;
        mask_reg     <= mask_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_mask_reg   <= m_mask_next;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    // insert results keep mask 0, so any_neighbour follows the mask alone
    assign cfg_ready        = 1'b1;
    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_neighbour_mask = m_mask_reg;
    assign m_any_neighbour  = |m_mask_reg;

endmodule

`default_nettype wire
